// File: rtl/core/ssp_pkg.sv
// Shared types and constants for the servo status packet receiver.
// No dependencies; used by the receiver top level and its checker.
`default_nettype none

package ssp_pkg;

    // Timer and limit widths
    localparam int TIMER_BITS  = 20;
    localparam int LIMIT_BITS  = 20;
    localparam int CMP_BITS    = (TIMER_BITS > LIMIT_BITS) ? TIMER_BITS : LIMIT_BITS;
    localparam logic [TIMER_BITS-1:0] TICK_MAX = {TIMER_BITS{1'b1}};
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1000);

    // Packet layout
    localparam int INDEX_BITS = 9;
    localparam logic [INDEX_BITS-1:0] SUM_FIRST_INDEX = INDEX_BITS'(2);
    localparam logic [INDEX_BITS-1:0] LENGTH_INDEX    = INDEX_BITS'(3);
    localparam logic [INDEX_BITS-1:0] INDEX_MAX       = {INDEX_BITS{1'b1}};

    // Request operation codes; code 3 carries no meaning and is ignored
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] byte_index;
        logic [7:0]            byte_value;
        logic                  last;
        logic                  timed_out;
        logic                  checksum_bad;
    } out_t;

endpackage

`default_nettype wire

// File: rtl/core/servo_status_packet_receiver.sv
// Servo status packet receiver: byte indexing, checksum check and inter-byte timeout.
// Depends on ssp_pkg for payload types and constants.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | into      | in_valid/in_ready   | ssp_pkg::in_t  (operation, byte)
//  out     | out of    | out_valid/out_ready | ssp_pkg::out_t (index, value, flags)
//  cfg     | into      | cfg_valid/cfg_ready | timeout limit, 20 bits
//
// One request per cycle while not stalled; its result, if any, appears in the output
// register in the cycle after acceptance. The state update and result are one add and
// compare between the request and the output register.
// Requests stall only while the output register holds an untaken result.
// Reset leaves the receiver idle with the limit at 1000 ticks.
`default_nettype none

module servo_status_packet_receiver (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire ssp_pkg::in_t                  in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output ssp_pkg::out_t                      out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ssp_pkg::LIMIT_BITS-1:0] cfg_data
);

    // Receiver state
    logic                              receiving_reg, receiving_next;
    logic [ssp_pkg::INDEX_BITS-1:0]    byte_count_reg, byte_count_next;
    logic [7:0]                        packet_length_reg, packet_length_next;
    logic [7:0]                        running_sum_reg, running_sum_next;
    logic [ssp_pkg::TIMER_BITS-1:0]    tick_count_reg, tick_count_next;
    logic [ssp_pkg::LIMIT_BITS-1:0]    limit_reg;

    logic                              out_valid_reg;
    ssp_pkg::out_t                     out_data_reg;

    logic                              accept;
    logic                              result_valid;
    ssp_pkg::out_t                     result;

    // Working values
    logic [7:0]                        length_eff;
    logic [ssp_pkg::INDEX_BITS-1:0]    final_index;
    logic                              is_final;
    logic [ssp_pkg::TIMER_BITS-1:0]    tick_inc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Final-byte detection; the length byte counts at once
    assign length_eff  = (byte_count_reg == ssp_pkg::LENGTH_INDEX) ? in_data.rx_byte
                                                                   : packet_length_reg;
    assign final_index = ssp_pkg::INDEX_BITS'(length_eff) + ssp_pkg::LENGTH_INDEX;
    assign is_final    = (byte_count_reg >= ssp_pkg::LENGTH_INDEX) &&
                         (byte_count_reg == final_index);
    assign tick_inc    = (tick_count_reg == ssp_pkg::TICK_MAX) ? tick_count_reg
                                                                : tick_count_reg + 1'b1;

    // Next state and result
    always_comb
    begin
        receiving_next     = receiving_reg;
        byte_count_next    = byte_count_reg;
        packet_length_next = packet_length_reg;
        running_sum_next   = running_sum_reg;
        tick_count_next    = tick_count_reg;
        result_valid       = 1'b0;
        result             = '0;
        result.byte_index  = byte_count_reg;

        case (in_data.operation)
            ssp_pkg::OP_START:
            begin
                receiving_next     = 1'b1;
                byte_count_next    = '0;
                packet_length_next = '0;
                running_sum_next   = '0;
                tick_count_next    = '0;
            end
            ssp_pkg::OP_BYTE:
            begin
                if (receiving_reg)
                begin
                    tick_count_next   = '0;
                    result_valid      = 1'b1;
                    result.byte_value = in_data.rx_byte;
                    if (byte_count_reg == ssp_pkg::LENGTH_INDEX)
                        packet_length_next = in_data.rx_byte;
                    if (is_final)
                    begin
                        result.last         = 1'b1;
                        result.checksum_bad = (~running_sum_reg) != in_data.rx_byte;
                        receiving_next      = 1'b0;
                    end
                    else
                    begin
                        if (byte_count_reg >= ssp_pkg::SUM_FIRST_INDEX)
                            running_sum_next = running_sum_reg + in_data.rx_byte;
                        if (byte_count_reg != ssp_pkg::INDEX_MAX)
                            byte_count_next = byte_count_reg + 1'b1;
                    end
                end
            end
            ssp_pkg::OP_TICK:
            begin
                if (receiving_reg)
                begin
                    tick_count_next = tick_inc;
                    if (ssp_pkg::CMP_BITS'(tick_inc) >= ssp_pkg::CMP_BITS'(limit_reg))
                    begin
                        result_valid     = 1'b1;
                        result.last      = 1'b1;
                        result.timed_out = 1'b1;
                        receiving_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                result_valid = 1'b0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg     <= 1'b0;
            byte_count_reg    <= '0;
            packet_length_reg <= '0;
            running_sum_reg   <= '0;
            tick_count_reg    <= '0;
        end
        else if (accept)
        begin
            receiving_reg     <= receiving_next;
            byte_count_reg    <= byte_count_next;
            packet_length_reg <= packet_length_next;
            running_sum_reg   <= running_sum_next;
            tick_count_reg    <= tick_count_next;
        end
    end

    // Timeout limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= ssp_pkg::LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= result_valid;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && result_valid)
            out_data_reg <= result;
    end

endmodule

`default_nettype wire

// File: rtl/core/ssp_checker.sv
// Port-level checks for the servo status packet receiver, bound to its top level.
// Depends on ssp_pkg and servo_status_packet_receiver.
`default_nettype none

module ssp_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire ssp_pkg::out_t out_data
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // A full, stalled output register blocks requests
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while result stalled");

    // A new result follows an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without request");

    // Timeout results are final, carry no byte and no checksum flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.timed_out |->
            out_data.last && (out_data.byte_value == 8'd0) && !out_data.checksum_bad)
        else $error("malformed timeout result");

    // Checksum flag only on the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !out_data.checksum_bad)
        else $error("checksum flag on a non-final byte");

endmodule

bind servo_status_packet_receiver ssp_checker u_ssp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
